// ===== rtl/core/obd2pid_pkg.sv =====
package obd2pid_pkg;

  localparam int unsigned X_W   = 32;  // operand: A, W or Q
  localparam int unsigned K_W   = 23;  // scale numerator, already times 2^16
  localparam int unsigned OFF_W = 15;  // whole-number offset
  localparam int unsigned R_W   = 8;   // remainder, below the divisor
  localparam int unsigned ACC_W = 47;  // unsigned floored value before offset
  localparam int unsigned VAL_W = 46;  // result width
  localparam int unsigned REC_W = 30;  // reciprocal width
  localparam int unsigned FRAC  = 16;  // fraction bits

  // Divisors left after folding 2^16 and powers of two into the numerator.
  typedef enum logic [2:0] {
    DIV_1,
    DIV_5,
    DIV_25,
    DIV_125,
    DIV_255
  } div_t;

  function automatic logic [R_W-1:0] div_value(input div_t d);
    logic [R_W-1:0] v;
    unique case (d)
      DIV_5:   v = 8'd5;
      DIV_25:  v = 8'd25;
      DIV_125: v = 8'd125;
      DIV_255: v = 8'd255;
      default: v = 8'd1;
    endcase
    return v;
  endfunction

  // floor(2^32 / d); the divide-by-one path bypasses the multiplier
  function automatic logic [REC_W-1:0] div_recip(input div_t d);
    logic [REC_W-1:0] m;
    unique case (d)
      DIV_5:   m = 30'd858993459;
      DIV_25:  m = 30'd171798691;
      DIV_125: m = 30'd34359738;
      DIV_255: m = 30'd16843009;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/obd2pid_cdiv.sv =====
// Three-stage divide by a small constant: reciprocal estimate, back-multiply,
// one correction step. Sideband rides alongside unchanged.
module obd2pid_cdiv #(
  parameter int unsigned SideW = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [obd2pid_pkg::X_W-1:0]   in_x,
  input  obd2pid_pkg::div_t             in_d,
  input  logic [SideW-1:0]              in_side,
  output logic                          out_valid,
  output logic [obd2pid_pkg::X_W-1:0]   out_q,
  output logic [obd2pid_pkg::R_W-1:0]   out_r,
  output logic [SideW-1:0]              out_side
);
  import obd2pid_pkg::*;

  localparam int unsigned P_W = X_W + REC_W;

  // stage a: x * reciprocal
  logic               valid_a;
  logic [P_W-1:0]     prod_a;
  logic [X_W-1:0]     x_a;
  div_t               d_a;
  logic [SideW-1:0]   side_a;

  // stage b: quotient estimate and estimate * d
  logic               valid_b;
  logic [X_W-1:0]     qest_b;
  logic [X_W-1:0]     qd_b;
  logic [X_W-1:0]     x_b;
  div_t               d_b;
  logic [SideW-1:0]   side_b;

  // stage c: corrected result
  logic               valid_c;
  logic [X_W-1:0]     q_c;
  logic [R_W-1:0]     r_c;
  logic [X_W-1:0]     x_c;
  div_t               d_c;
  logic [SideW-1:0]   side_c;

  logic [X_W-1:0]     qest_next;
  logic [X_W+R_W-1:0] qd_full;
  logic [X_W-1:0]     diff;
  logic [R_W:0]       rem_raw;
  logic [R_W:0]       dval_b;

  always_comb begin
    // estimate is q or q-1
    qest_next = (d_a == DIV_1) ? x_a : X_W'(prod_a[P_W-1:X_W]);
    qd_full   = qest_next * div_value(d_a);
    diff      = x_b - qd_b;
    rem_raw   = diff[R_W:0];
    dval_b    = {1'b0, div_value(d_b)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
    end else begin
      valid_a <= in_valid;
      valid_b <= valid_a;
      valid_c <= valid_b;
    end
    prod_a <= in_x * div_recip(in_d);
    x_a    <= in_x;
    d_a    <= in_d;
    side_a <= in_side;

    qest_b <= qest_next;
    qd_b   <= qd_full[X_W-1:0];
    x_b    <= x_a;
    d_b    <= d_a;
    side_b <= side_a;

    if (rem_raw >= dval_b) begin
      q_c <= qest_b + X_W'(1);
      r_c <= R_W'(rem_raw - dval_b);
    end else begin
      q_c <= qest_b;
      r_c <= rem_raw[R_W-1:0];
    end
    x_c    <= x_b;
    d_c    <= d_b;
    side_c <= side_b;
  end

  assign out_valid = valid_c;
  assign out_q     = q_c;
  assign out_r     = r_c;
  assign out_side  = side_c;

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    valid_c |-> (r_c < div_value(d_c)))
    else $error("remainder not below divisor");

  a_quot_exact: assert property (@(posedge clk) disable iff (rst)
    valid_c |-> ((40'(q_c) * 40'(div_value(d_c)) + 40'(r_c)) == 40'(x_c)))
    else $error("q*d + r does not rebuild the dividend");

  a_valid_chain: assert property (@(posedge clk) disable iff (rst)
    valid_c |-> $past(valid_b))
    else $error("output valid without a stage-b item");

endmodule

// ===== rtl/core/obd2_pid_value_decoder_unit.sv =====
// Channel  | Ports                                      | Handshake
// ---------+--------------------------------------------+------------------------------
// command  | pid_code, byte_a, byte_b, byte_c, byte_d   | taken when start & !busy
// result   | scaled_value (s46, 16 frac), pid_known     | one cycle, marked by done
//
// One item accepted per cycle while busy is low; its result appears on done
// after the decode stage, the two constant dividers (three stages each), the
// product stage between them and the final offset stage.
// rst (synchronous) clears the valid bits; busy is high through reset and the
// cycle after, low at all other times.
// The receiver cannot stall, so nothing is ever held back inside the pipe.
module obd2_pid_value_decoder_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         pid_code,
  input  logic [7:0]         byte_a,
  input  logic [7:0]         byte_b,
  input  logic [7:0]         byte_c,
  input  logic [7:0]         byte_d,
  output logic               done,
  output logic signed [45:0] scaled_value,
  output logic               pid_known
);
  import obd2pid_pkg::*;

  // value * 2^16 = floor(x * k / d) - off * 2^16
  // x is A, W = {A,B} or Q = {A,B,C,D}; k already holds 2^16 and any
  // power-of-two part of the divisor, so d is 1, 5, 25, 125 or 255.
  typedef enum logic [1:0] {
    SRC_A,
    SRC_W,
    SRC_Q
  } src_t;

  localparam int unsigned SIDE_A_W = 3 + K_W + OFF_W + 1;
  localparam int unsigned SIDE_B_W = ACC_W + OFF_W + 1;
  localparam int unsigned PROD_W   = X_W + K_W;

  // ---- decode (comb) ----
  src_t             src;
  logic [K_W-1:0]   k_dec;
  div_t             d_dec;
  logic [OFF_W-1:0] off_dec;
  logic             known_dec;
  logic [X_W-1:0]   x_dec;
  logic             accept;

  always_comb begin
    src       = SRC_A;
    k_dec     = 23'd65536;
    d_dec     = DIV_1;
    off_dec   = '0;
    known_dec = 1'b1;
    unique case (pid_code) inside
      8'h04, 8'h11, 8'h2C, 8'h2E, 8'h2F, 8'h45, [8'h47:8'h4C], 8'h52, 8'h5A,
      8'h5B: begin
        k_dec = 23'd6553600;
        d_dec = DIV_255;
      end
      8'h05, 8'h0F, 8'h46, 8'h5C, 8'h67, 8'h68: begin
        off_dec = 15'd40;
      end
      [8'h06:8'h09], 8'h2D, [8'h55:8'h58]: begin
        k_dec   = 23'd51200;   // 100/128 folded into the shift
        off_dec = 15'd100;
      end
      8'h5D: begin
        k_dec   = 23'd51200;
        off_dec = 15'd210;
      end
      8'h0A: begin
        k_dec = 23'd196608;
      end
      8'h0B, 8'h0D, 8'h30, 8'h33, 8'h4F: begin
      end
      8'h0E: begin
        k_dec   = 23'd32768;
        off_dec = 15'd64;
      end
      [8'h14:8'h1B]: begin
        k_dec = 23'd8192;
        d_dec = DIV_25;
      end
      8'h61, 8'h62, 8'h64: begin
        off_dec = 15'd125;
      end
      8'h0C, 8'h32: begin
        src   = SRC_W;
        k_dec = 23'd16384;
      end
      8'h10, 8'h53: begin
        src   = SRC_W;
        k_dec = (pid_code == 8'h10) ? 23'd16384 : 23'd8192;
        d_dec = DIV_25;
      end
      8'h1F, 8'h21, 8'h31, 8'h4D, 8'h4E, 8'h59, 8'h63: begin
        src = SRC_W;
      end
      8'h22: begin
        src   = SRC_W;
        k_dec = 23'd647168;    // 79/1000
        d_dec = DIV_125;
      end
      8'h23: begin
        src   = SRC_W;
        k_dec = 23'd655360;
      end
      [8'h24:8'h2B], [8'h34:8'h3B], 8'h44: begin
        src   = SRC_W;
        k_dec = 23'd2;         // W / 32768
      end
      [8'h3C:8'h3F], 8'h7C: begin
        src     = SRC_W;
        k_dec   = 23'd16384;
        d_dec   = DIV_25;
        off_dec = 15'd40;
      end
      8'h42: begin
        src   = SRC_W;
        k_dec = 23'd8192;
        d_dec = DIV_125;
      end
      8'h43: begin
        src   = SRC_W;
        k_dec = 23'd6553600;
        d_dec = DIV_255;
      end
      8'h54: begin
        src     = SRC_W;
        off_dec = 15'd32767;
      end
      8'h5E: begin
        src   = SRC_W;
        k_dec = 23'd16384;
        d_dec = DIV_5;
      end
      8'h66: begin
        src   = SRC_W;
        k_dec = 23'd2048;
      end
      8'hA6: begin
        src   = SRC_Q;
        k_dec = 23'd32768;     // Q / 10
        d_dec = DIV_5;
      end
      default: begin
        // unknown PID: zero scale and no offset give a zero result
        k_dec     = '0;
        known_dec = 1'b0;
      end
    endcase

    unique case (src)
      SRC_W:   x_dec = {16'b0, byte_a, byte_b};
      SRC_Q:   x_dec = {byte_a, byte_b, byte_c, byte_d};
      default: x_dec = {24'b0, byte_a};
    endcase
  end

  assign accept = start & ~busy;

  // ---- stage 1: decoded rule ----
  logic             v1;
  logic [X_W-1:0]   x1;
  logic [K_W-1:0]   k1;
  div_t             d1;
  logic [OFF_W-1:0] off1;
  logic             known1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      v1   <= 1'b0;
    end else begin
      busy <= 1'b0;
      v1   <= accept;
    end
    x1     <= x_dec;
    k1     <= k_dec;
    d1     <= d_dec;
    off1   <= off_dec;
    known1 <= known_dec;
  end

  // ---- first divider: x = q*d + r ----
  logic                v_a;
  logic [X_W-1:0]      q_a;
  logic [R_W-1:0]      r_a;
  logic [SIDE_A_W-1:0] side_a;

  obd2pid_cdiv #(.SideW(SIDE_A_W)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v1),
    .in_x     (x1),
    .in_d     (d1),
    .in_side  ({d1, k1, off1, known1}),
    .out_valid(v_a),
    .out_q    (q_a),
    .out_r    (r_a),
    .out_side (side_a)
  );

  // ---- stage 5: floor(x*k/d) = q*k + floor(r*k/d) ----
  div_t               d_a;
  logic [K_W-1:0]     k_a;
  logic [OFF_W-1:0]   off_a;
  logic               known_a;
  logic [PROD_W-1:0]  hi_full;
  logic [R_W+K_W-1:0] lo_full;

  logic               v5;
  logic [ACC_W-1:0]   hi5;
  logic [R_W+K_W-1:0] lon5;
  div_t               d5;
  logic [OFF_W-1:0]   off5;
  logic               known5;

  always_comb begin
    d_a     = div_t'(side_a[SIDE_A_W-1 -: 3]);
    k_a     = side_a[K_W+OFF_W : OFF_W+1];
    off_a   = side_a[OFF_W:1];
    known_a = side_a[0];
    hi_full = q_a * k_a;
    lo_full = r_a * k_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v_a;
    end
    hi5    <= hi_full[ACC_W-1:0];  // true value stays below 2^47
    lon5   <= lo_full;
    d5     <= d_a;
    off5   <= off_a;
    known5 <= known_a;
  end

  // ---- second divider: floor(r*k/d) ----
  logic                v_b;
  logic [X_W-1:0]      q_b;
  logic [R_W-1:0]      r_b;
  logic [SIDE_B_W-1:0] side_b;

  obd2pid_cdiv #(.SideW(SIDE_B_W)) u_div_frac (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v5),
    .in_x     (X_W'(lon5)),
    .in_d     (d5),
    .in_side  ({hi5, off5, known5}),
    .out_valid(v_b),
    .out_q    (q_b),
    .out_r    (r_b),
    .out_side (side_b)
  );

  // ---- output stage: add parts, take off the offset ----
  logic [ACC_W-1:0] hi_b;
  logic [ACC_W-1:0] off_fix;
  logic [ACC_W-1:0] total;
  logic             frac_zero;

  always_comb begin
    hi_b      = side_b[SIDE_B_W-1 -: ACC_W];
    off_fix   = ACC_W'({side_b[OFF_W:1], FRAC'(0)});
    total     = hi_b + ACC_W'(q_b) - off_fix;
    frac_zero = (r_b == '0);  // remainder of the second step is dropped by flooring
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v_b;
    end
    scaled_value <= signed'(total[VAL_W-1:0]);
    pid_known    <= side_b[0];
  end

  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    done && !pid_known |-> (scaled_value == '0))
    else $error("unknown PID gave a non-zero value");

  a_unknown_exact: assert property (@(posedge clk) disable iff (rst)
    v_b && !side_b[0] |-> frac_zero)
    else $error("unknown PID left a remainder");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !v1)
    else $error("item entered during reset");

endmodule
